@@ hdl/dmhq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmhq_pkg
// shared types, codes and defaults of the d-ary min-heap priority queue
// ----------------------------------------------------------------------------
package dmhq_pkg;

    localparam int ARITY_DEFAULT    = 4;
    localparam int CAPACITY_DEFAULT = 64;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int TAG_W    = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC_KEY  = 3'd3;
    localparam logic [OP_W-1:0] OP_INC_KEY  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LAST,
        ST_UP_DIV,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_START,
        ST_DN_SCAN,
        ST_FIN
    } state_t;

endpackage : dmhq_pkg
`default_nettype wire

@@ hdl/dmhq_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmhq_req_if
// request channel of the heap queue: operation, key, tag and slot
// ----------------------------------------------------------------------------
interface dmhq_req_if
    import dmhq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] payload;
    logic [POS_W-1:0] position;

    modport source (output valid, output op, output key, output payload,
                    output position, input ready);
    modport sink   (input valid, input op, input key, input payload,
                    input position, output ready);
endinterface : dmhq_req_if
`default_nettype wire

@@ hdl/dmhq_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmhq_rsp_if
// response channel of the heap queue: status, minimum entry and fill level
// ----------------------------------------------------------------------------
interface dmhq_rsp_if
    import dmhq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_payload;
    logic [FILL_W-1:0]   fill;

    modport source (output valid, output status, output out_key,
                    output out_payload, output fill, input ready);
    modport sink   (input valid, input status, input out_key,
                    input out_payload, input fill, output ready);
endinterface : dmhq_rsp_if
`default_nettype wire

@@ hdl/dmhq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmhq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dmhq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule : dmhq_ram
`default_nettype wire

@@ hdl/dary_min_heap_queue_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dary_min_heap_queue_unit
// d-ary min-heap priority queue with push, pop, peek and key changes
// ----------------------------------------------------------------------------
// channel  modport  fields
// req      sink     op, key, payload, position
// rsp      source   status, out_key, out_payload, fill
//
// one request at a time through one simple dual-port ram with registered read.
// push and decrease key sift the entry up, one parent read and compare per level;
// pop refills the root from the last entry; pop and increase key sift down, reading each child per level;
// peek, undefined ops, refused or ignored requests and pop of the last entry move no entry.
// reset clears count and control state only; an untaken response holds the next
// request in its final state, and req ready stays low while a request is in work.
// ----------------------------------------------------------------------------
module dary_min_heap_queue_unit
    import dmhq_pkg::*;
#(
    parameter int ARITY    = ARITY_DEFAULT,
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    dmhq_req_if.sink   req,
    dmhq_rsp_if.source rsp
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int KW    = $clog2(ARITY);
    localparam int XW    = (AW + 1 > POS_W) ? AW + 1 : POS_W;
    localparam int LW    = AW + KW + 2;
    localparam int SH    = AW + 1;
    localparam int PRW   = AW + SH;
    localparam int RECIP = (1 << SH) / ARITY;
    localparam int EW    = $bits(entry_t);

    state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       pick_reg, pick_next;
    logic [AW-1:0]       child_reg, child_next;
    logic [KW-1:0]       kcnt_reg, kcnt_next;
    logic [AW-1:0]       quot_reg, quot_next;
    entry_t              cur_reg, cur_next;
    entry_t              best_reg, best_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [KEY_W-1:0]    rsp_key_reg, rsp_key_next;
    logic [TAG_W-1:0]    rsp_tag_reg, rsp_tag_next;
    logic [FILL_W-1:0]   rsp_fill_reg, rsp_fill_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    entry_t        rd_entry;

    logic           req_fire;
    logic           rsp_free;
    logic           at_capacity;
    logic           no_entries;
    logic           pos_empty;
    logic           dec_bad;
    logic           inc_bad;
    logic [CW-1:0]  count_dec;
    logic [LW-1:0]  lo_w;
    logic           lo_beyond;
    logic           child_less;
    entry_t         scan_best;
    logic [AW-1:0]  scan_pick;
    logic [AW:0]    child_inc;
    logic           scan_more;
    logic [AW-1:0]  up_x;
    logic [PRW-1:0] quot_prod;
    logic [LW-1:0]  up_rem;
    logic [AW-1:0]  parent_idx;
    logic           parent_gt;

    dmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry   = entry_t'(ram_rdata);
    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    assign at_capacity = XW'(count_reg) >= XW'(CAPACITY);
    assign no_entries  = (count_reg == '0);
    assign pos_empty  = XW'(pos_reg) >= XW'(count_reg);
    assign dec_bad    = key_reg >= rd_entry.key;
    assign inc_bad    = key_reg <= rd_entry.key;
    assign count_dec  = count_reg - CW'(1);

    // first child of the current slot
    assign lo_w       = LW'(idx_reg) * LW'(ARITY) + LW'(1);
    assign lo_beyond  = lo_w >= LW'(count_reg);

    // strict compare keeps the lowest-numbered child on ties
    assign child_less = rd_entry.key < best_reg.key;
    assign scan_best  = child_less ? rd_entry : best_reg;
    assign scan_pick  = child_less ? child_reg : pick_reg;
    assign child_inc  = (AW + 1)'(child_reg) + (AW + 1)'(1);
    assign scan_more  = (kcnt_reg != KW'(ARITY - 1))
                     && (child_inc < (AW + 1)'(count_reg));

    // parent = (i - 1) / arity by reciprocal, estimate low by at most one
    assign up_x       = idx_reg - AW'(1);
    assign quot_prod  = PRW'(up_x) * PRW'(RECIP);
    assign up_rem     = LW'(up_x) - LW'(quot_reg) * LW'(ARITY);
    assign parent_idx = quot_reg + AW'(up_rem >= LW'(ARITY));
    assign parent_gt  = rd_entry.key > cur_reg.key;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        state_next = at_capacity ? ST_FIN : ST_UP_DIV;
                    end
                    OP_POP:
                    begin
                        state_next = (no_entries || count_dec == '0) ? ST_FIN : ST_LAST;
                    end
                    OP_DEC_KEY:
                    begin
                        state_next = (pos_empty || dec_bad) ? ST_FIN : ST_UP_DIV;
                    end
                    OP_INC_KEY:
                    begin
                        state_next = (pos_empty || inc_bad) ? ST_FIN : ST_DN_START;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_LAST:
            begin
                state_next = ST_DN_START;
            end
            ST_UP_DIV:
            begin
                state_next = (idx_reg == '0) ? ST_FIN : ST_UP_RD;
            end
            ST_UP_RD:
            begin
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                state_next = parent_gt ? ST_UP_DIV : ST_FIN;
            end
            ST_DN_START:
            begin
                state_next = lo_beyond ? ST_FIN : ST_DN_SCAN;
            end
            ST_DN_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = (scan_pick == idx_reg) ? ST_FIN : ST_DN_START;
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        pick_next       = pick_reg;
        child_next      = child_reg;
        kcnt_next       = kcnt_reg;
        quot_next       = quot_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_tag_next    = res_tag_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_tag_next    = rsp_tag_reg;
        rsp_fill_next   = rsp_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = cur_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = req.op;
                    key_next        = req.key;
                    tag_next        = req.payload;
                    pos_next        = req.position;
                    res_status_next = STAT_DONE;
                    res_key_next    = '0;
                    res_tag_next    = '0;
                    ram_re          = 1'b1;
                    ram_raddr       = (req.op == OP_POP || req.op == OP_PEEK)
                                    ? '0 : AW'(req.position);
                end
            end
            ST_EVAL:
            begin
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (at_capacity)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            cur_next   = '{key: key_reg, tag: tag_reg};
                            idx_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (no_entries)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            res_key_next = rd_entry.key;
                            res_tag_next = rd_entry.tag;
                            count_next   = count_dec;
                            // fetch the last entry to refill the root
                            ram_re       = 1'b1;
                            ram_raddr    = AW'(count_dec);
                        end
                    end
                    OP_PEEK:
                    begin
                        if (no_entries)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            res_key_next = rd_entry.key;
                            res_tag_next = rd_entry.tag;
                        end
                    end
                    OP_DEC_KEY, OP_INC_KEY:
                    begin
                        if (pos_empty || (op_reg == OP_DEC_KEY ? dec_bad : inc_bad))
                        begin
                            res_status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            cur_next = '{key: key_reg, tag: rd_entry.tag};
                            idx_next = AW'(pos_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LAST:
            begin
                cur_next = rd_entry;
                idx_next = '0;
            end
            ST_UP_DIV:
            begin
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    quot_next = AW'(quot_prod >> SH);
                end
            end
            ST_UP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = parent_idx;
                pick_next = parent_idx;
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (parent_gt)
                begin
                    // parent moves down into the hole
                    ram_wdata = rd_entry;
                    idx_next  = pick_reg;
                end
            end
            ST_DN_START:
            begin
                if (lo_beyond)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(lo_w);
                    child_next = AW'(lo_w);
                    kcnt_next  = '0;
                    best_next  = cur_reg;
                    pick_next  = idx_reg;
                end
            end
            ST_DN_SCAN:
            begin
                best_next = scan_best;
                pick_next = scan_pick;
                if (scan_more)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(child_inc);
                    child_next = AW'(child_inc);
                    kcnt_next  = kcnt_reg + KW'(1);
                end
                else
                begin
                    ram_we = 1'b1;
                    if (scan_pick != idx_reg)
                    begin
                        // smallest child moves up into the hole
                        ram_wdata = scan_best;
                        idx_next  = scan_pick;
                    end
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_key_next    = res_key_reg;
                    rsp_tag_next    = res_tag_reg;
                    rsp_fill_next   = FILL_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pick_reg       <= pick_next;
        child_reg      <= child_next;
        kcnt_reg       <= kcnt_next;
        quot_reg       <= quot_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_tag_reg    <= res_tag_next;
        rsp_status_reg <= rsp_status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_tag_reg    <= rsp_tag_next;
        rsp_fill_reg   <= rsp_fill_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.out_key     = rsp_key_reg;
    assign rsp.out_payload = rsp_tag_reg;
    assign rsp.fill        = rsp_fill_reg;
endmodule : dary_min_heap_queue_unit
`default_nettype wire

@@ tb/sv/dary_min_heap_queue_unit_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dary_min_heap_queue_unit_tb
// self-checking bench for the d-ary min-heap queue: a short table of directed
// requests, then random phases that fill, drain and mix the heap, with random
// gaps on both channels, one long response back-pressure and one drain pause.
// every response is compared field by field against the table or an in-bench heap model.
// ----------------------------------------------------------------------------
module dary_min_heap_queue_unit_tb;
    import dmhq_pkg::*;

    localparam int ARITY          = ARITY_DEFAULT;
    localparam int CAPACITY       = CAPACITY_DEFAULT;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [TAG_W-1:0] TAG_MAX = '1;
    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] payload;
        logic [POS_W-1:0] position;
    } heap_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    min_key;
        logic [TAG_W-1:0]    min_tag;
        logic [FILL_W-1:0]   fill;
    } heap_result_t;

    typedef struct packed {
        heap_request_t request;
        logic          typed;
        heap_result_t  result;
    } directed_row_t;

    logic clk;
    logic rst_n;

    dmhq_req_if req_ch ();
    dmhq_rsp_if rsp_ch ();

    dary_min_heap_queue_unit #(
        .ARITY    (ARITY),
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // heap model state
    logic [KEY_W-1:0] model_keys [CAPACITY];
    logic [TAG_W-1:0] model_tags [CAPACITY];
    int unsigned      model_count = 0;

    heap_result_t pending_results [$];
    int unsigned  error_count      = 0;
    bit           gaps_on          = 1'b1;
    bit           rsp_hold_pending = 1'b0;
    int unsigned  next_gap         = 0;
    bit           valid_kept       = 1'b0;

    // typed expectations only where they follow at a glance
    directed_row_t directed_rows [24] = '{
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_EMPTY,   64'd0,   32'd0,   7'd0}},
        '{'{OP_PEEK,      64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_EMPTY,   64'd0,   32'd0,   7'd0}},
        '{'{OP_DEC_KEY,   64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_IGNORED, 64'd0,   32'd0,   7'd0}},
        '{'{OP_INC_KEY,   KEY_MAX, TAG_MAX,      6'd63}, 1'b1, '{STAT_IGNORED, 64'd0,   32'd0,   7'd0}},
        '{'{OP_UNUSED_LO, KEY_MAX, TAG_MAX,      6'd63}, 1'b1, '{STAT_DONE,    64'd0,   32'd0,   7'd0}},
        '{'{OP_UNUSED_HI, 64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_DONE,    64'd0,   32'd0,   7'd0}},
        '{'{OP_PUSH,      KEY_MAX, TAG_MAX,      6'd0 }, 1'b1, '{STAT_DONE,    64'd0,   32'd0,   7'd1}},
        '{'{OP_PEEK,      64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_DONE,    KEY_MAX, TAG_MAX, 7'd1}},
        '{'{OP_PUSH,      64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_DONE,    64'd0,   32'd0,   7'd2}},
        '{'{OP_PEEK,      64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_DONE,    64'd0,   32'd0,   7'd2}},
        '{'{OP_PUSH,      64'd5,   32'ha5a5a5a5, 6'd0 }, 1'b0, '0},
        '{'{OP_PUSH,      64'd5,   32'h5a5a5a5a, 6'd0 }, 1'b0, '0},
        '{'{OP_PUSH,      64'd3,   32'h00000003, 6'd0 }, 1'b0, '0},
        // equal key is not a decrease
        '{'{OP_DEC_KEY,   64'd5,   32'd0,        6'd2 }, 1'b0, '0},
        '{'{OP_DEC_KEY,   64'd1,   32'd0,        6'd4 }, 1'b0, '0},
        '{'{OP_INC_KEY,   64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_INC_KEY,   KEY_MAX, 32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_DEC_KEY,   64'd0,   32'd0,        6'd5 }, 1'b1, '{STAT_IGNORED, 64'd0,   32'd0,   7'd5}},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b0, '0},
        '{'{OP_POP,       64'd0,   32'd0,        6'd0 }, 1'b1, '{STAT_EMPTY,   64'd0,   32'd0,   7'd0}}
    };

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = model_keys[a];
        t = model_tags[a];
        model_keys[a] = model_keys[b];
        model_tags[a] = model_tags[b];
        model_keys[b] = k;
        model_tags[b] = t;
    endfunction

    // sift up, stopping on a parent that is less or equal
    function automatic void climb(int unsigned slot);
        int unsigned up;
        while (slot > 0)
        begin
            up = (slot - 1) / ARITY;
            if (model_keys[up] <= model_keys[slot])
                break;
            swap_slots(up, slot);
            slot = up;
        end
    endfunction

    // sift down to the smallest strictly smaller child, lowest-numbered on ties
    function automatic void settle(int unsigned slot);
        int unsigned child_lo;
        int unsigned child_hi;
        int unsigned pick;
        forever
        begin
            child_lo = ARITY * slot + 1;
            if (child_lo >= model_count)
                break;
            child_hi = child_lo + ARITY;
            if (child_hi > model_count)
                child_hi = model_count;
            pick = slot;
            for (int unsigned c = child_lo; c < child_hi; c++)
                if (model_keys[c] < model_keys[pick])
                    pick = c;
            if (pick == slot)
                break;
            swap_slots(slot, pick);
            slot = pick;
        end
    endfunction

    function automatic heap_result_t heap_apply(heap_request_t r);
        heap_result_t res;
        int unsigned  slot;
        res = '0;
        res.status = STAT_DONE;
        slot = 32'(r.position);
        case (r.op)
            OP_PUSH:
                if (model_count >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    slot = model_count;
                    model_count++;
                    model_keys[slot] = r.key;
                    model_tags[slot] = r.payload;
                    climb(slot);
                end
            OP_POP, OP_PEEK:
                if (model_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.min_key = model_keys[0];
                    res.min_tag = model_tags[0];
                    if (r.op == OP_POP)
                    begin
                        model_count--;
                        if (model_count > 0)
                        begin
                            model_keys[0] = model_keys[model_count];
                            model_tags[0] = model_tags[model_count];
                            settle(0);
                        end
                    end
                end
            OP_DEC_KEY:
                if (slot >= model_count || r.key >= model_keys[slot])
                    res.status = STAT_IGNORED;
                else
                begin
                    model_keys[slot] = r.key;
                    climb(slot);
                end
            OP_INC_KEY:
                if (slot >= model_count || r.key <= model_keys[slot])
                    res.status = STAT_IGNORED;
                else
                begin
                    model_keys[slot] = r.key;
                    settle(slot);
                end
            default:
                ;
        endcase
        res.fill = FILL_W'(model_count);
        return res;
    endfunction

    // small keys make ties common, full-width keys exercise every bit
    function automatic logic [KEY_W-1:0] draw_key();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return KEY_W'($urandom_range(0, 31));
        else if (pick < 8)
            return {$urandom, $urandom};
        else if (pick == 8)
            return '0;
        else
            return KEY_MAX;
    endfunction

    function automatic heap_request_t draw_request(int unsigned push_pct, int unsigned pop_pct);
        heap_request_t    r;
        int unsigned      roll;
        logic [KEY_W-1:0] cur;
        logic [KEY_W-1:0] step;
        logic [KEY_W-1:0] span;
        r.op       = OP_PEEK;
        r.key      = draw_key();
        r.payload  = $urandom;
        r.position = POS_W'($urandom_range(0, CAPACITY - 1));
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            r.op = OP_PUSH;
        else if (roll < push_pct + pop_pct)
            r.op = OP_POP;
        else
        begin
            roll = $urandom_range(0, 9);
            if (roll < 2)
                r.op = OP_PEEK;
            else if (roll < 5)
                r.op = OP_DEC_KEY;
            else if (roll < 9)
                r.op = OP_INC_KEY;
            else
                r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        // most key changes hit a live slot and move the key the right way
        if ((r.op == OP_DEC_KEY || r.op == OP_INC_KEY) && model_count > 0
            && $urandom_range(0, 9) < 8)
        begin
            r.position = POS_W'($urandom_range(0, model_count - 1));
            cur = model_keys[r.position];
            step = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 15))
                                               : {$urandom, $urandom};
            if (r.op == OP_DEC_KEY)
                r.key = (cur == '0) ? '0 : cur - 1 - (step % cur);
            else
            begin
                span = KEY_MAX - cur;
                r.key = (span == '0) ? KEY_MAX : cur + 1 + (step % span);
            end
        end
        return r;
    endfunction

    task automatic offer_request(input heap_request_t r, output heap_result_t predicted);
        repeat (next_gap) @(posedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.op       <= r.op;
        req_ch.key      <= r.key;
        req_ch.payload  <= r.payload;
        req_ch.position <= r.position;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = heap_apply(r);
        next_gap = gaps_on ? $urandom_range(0, 12) : 0;
        // valid stays up only when the next request follows at once
        valid_kept = (next_gap == 0);
        if (!valid_kept)
            req_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned count, int unsigned push_pct, int unsigned pop_pct);
        heap_result_t predicted;
        repeat (count)
        begin
            offer_request(draw_request(push_pct, pop_pct), predicted);
            pending_results.push_back(predicted);
        end
    endtask

    task automatic drain_results();
        if (valid_kept)
        begin
            req_ch.valid <= 1'b0;
            valid_kept = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // response side: check, then random stalls and the one long hold
    initial
    begin
        int unsigned  stall_left;
        int unsigned  hold_left;
        heap_result_t want;
        stall_left = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $error("response with no request pending: status %0d fill %0d",
                           rsp_ch.status, rsp_ch.fill);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", KEY_W'(want.status), KEY_W'(rsp_ch.status));
                    compare_field("out_key", want.min_key, rsp_ch.out_key);
                    compare_field("out_payload", KEY_W'(want.min_tag),
                                  KEY_W'(rsp_ch.out_payload));
                    compare_field("fill", KEY_W'(want.fill), KEY_W'(rsp_ch.fill));
                end
                stall_left = gaps_on ? $urandom_range(0, 12) : 0;
            end
            if (rsp_hold_pending)
            begin
                hold_left = HOLD_CYCLES;
                rsp_hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("dary_min_heap_queue_unit_tb: errors");
        $finish;
    end

    initial
    begin
        heap_result_t predicted;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_PUSH;
        req_ch.key      <= '0;
        req_ch.payload  <= '0;
        req_ch.position <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].request, predicted);
            pending_results.push_back(directed_rows[i].typed ? directed_rows[i].result
                                                             : predicted);
        end

        run_phase(200, 35, 30);
        // long response hold while requests keep coming back to back
        gaps_on = 1'b0;
        rsp_hold_pending = 1'b1;
        run_phase(30, 45, 20);
        gaps_on = 1'b1;
        drain_results();
        // push-heavy phase toward full, then pop-heavy phase toward empty
        run_phase(150, 80, 8);
        run_phase(150, 15, 60);
        gaps_on = 1'b0;
        run_phase(200, 35, 30);
        gaps_on = 1'b1;
        run_phase(350, 35, 30);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("dary_min_heap_queue_unit_tb: clean");
        else
            $display("dary_min_heap_queue_unit_tb: errors");
        $finish;
    end

endmodule : dary_min_heap_queue_unit_tb
`default_nettype wire
